/* rtl/core/pwmfdm_pkg.sv */
// Package for the PWM frequency and duty meter.
// Widths, constants and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package pwmfdm_pkg;

    // tick counter width (8..32)
    localparam int CNT_W   = 16;
    // result field widths
    localparam int OUT_W   = 16;
    localparam int DUTY_W  = 7;
    localparam int CLK_W   = 27;

    localparam int FREQ_SCALE = 1000;
    localparam int DUTY_SCALE = 100;

    // divider: dividend is clock_hz or high*100, divisor is period*1000 or period
    localparam int DVD_W  = (CNT_W + 7 > CLK_W) ? CNT_W + 7 : CLK_W;
    localparam int DVS_W  = CNT_W + 10;
    localparam int STEP_W = $clog2(DVD_W + 1);

    // APB register map
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int IDX_W  = ADDR_W - 2;
    localparam logic [IDX_W-1:0] IDX_CLOCK_HZ = '0;
    localparam logic [CLK_W-1:0] CLOCK_HZ_RST = CLK_W'(8000000);

    // controller -> datapath
    typedef struct packed {
        logic take;         // tick transaction accepted
        logic cap_first;    // capture first rising edge
        logic cap_fall;     // capture falling edge
        logic cap_second;   // capture second rising edge, restart counter
        logic div_start;
        logic div_sel_duty; // 0: frequency division, 1: duty division
        logic freq_latch;
        logic out_load;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic rise;
        logic fall;
        logic range_ok;
        logic div_busy;
        logic out_pending;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/pwmfdm_ctrl.sv */
// Controller for the PWM meter: capture phases and division sequencing.
// Depends on pwmfdm_pkg.
`default_nettype none

module pwmfdm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire pwmfdm_pkg::dp_status_t sts,
    output pwmfdm_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [7:0] {
        ST_RISE1   = 8'b0000_0001,
        ST_FALL    = 8'b0000_0010,
        ST_RISE2   = 8'b0000_0100,
        ST_START_F = 8'b0000_1000,
        ST_WAIT_F  = 8'b0001_0000,
        ST_START_D = 8'b0010_0000,
        ST_WAIT_D  = 8'b0100_0000,
        ST_DONE    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // hold off ticks that could finish a measurement while a result is unread
    assign in_ready = (state_reg == ST_RISE1) || (state_reg == ST_FALL) ||
                      ((state_reg == ST_RISE2) && !sts.out_pending);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RISE1:
            begin
                if (accept && sts.rise)
                    state_next = ST_FALL;
            end
            ST_FALL:
            begin
                if (accept && sts.fall)
                    state_next = ST_RISE2;
            end
            ST_RISE2:
            begin
                if (accept && sts.rise)
                    state_next = sts.range_ok ? ST_START_F : ST_DONE;
            end
            ST_START_F:
                state_next = ST_WAIT_F;
            ST_WAIT_F:
            begin
                if (!sts.div_busy)
                    state_next = ST_START_D;
            end
            ST_START_D:
                state_next = ST_WAIT_D;
            ST_WAIT_D:
            begin
                if (!sts.div_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
                state_next = ST_RISE1;
            default:
                state_next = ST_RISE1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_RISE1;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd              = '0;
        cmd.take         = accept;
        cmd.cap_first    = accept && (state_reg == ST_RISE1) && sts.rise;
        cmd.cap_fall     = accept && (state_reg == ST_FALL) && sts.fall;
        cmd.cap_second   = accept && (state_reg == ST_RISE2) && sts.rise;
        cmd.div_start    = (state_reg == ST_START_F) || (state_reg == ST_START_D);
        cmd.div_sel_duty = (state_reg == ST_START_D);
        cmd.freq_latch   = (state_reg == ST_WAIT_F) && !sts.div_busy;
        cmd.out_load     = (state_reg == ST_DONE);
    end

endmodule

`default_nettype wire

/* rtl/core/pwmfdm_dpath.sv */
// Datapath for the PWM meter: edge detect, tick counter, captures,
// shared restoring divider and result register. Depends on pwmfdm_pkg.
`default_nettype none

module pwmfdm_dpath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                signal_level,
    input  wire logic [pwmfdm_pkg::CLK_W-1:0]        clock_hz,
    input  wire pwmfdm_pkg::ctrl_cmd_t               cmd,
    output pwmfdm_pkg::dp_status_t                   sts,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     in_range,
    output logic [pwmfdm_pkg::OUT_W-1:0]             high_ticks,
    output logic [pwmfdm_pkg::OUT_W-1:0]             period_ticks,
    output logic [pwmfdm_pkg::OUT_W-1:0]             freq_khz,
    output logic [pwmfdm_pkg::DUTY_W-1:0]            duty_percent
);

    localparam int CW  = pwmfdm_pkg::CNT_W;
    localparam int DDW = pwmfdm_pkg::DVD_W;
    localparam int DSW = pwmfdm_pkg::DVS_W;
    localparam int SW  = pwmfdm_pkg::STEP_W;
    localparam int OW  = pwmfdm_pkg::OUT_W;
    localparam int UW  = pwmfdm_pkg::DUTY_W;

    // capture state
    logic          prev_level_reg;
    logic [CW-1:0] tick_reg;
    logic [CW-1:0] tick_next;
    logic [CW-1:0] first_rise_reg;
    logic [CW-1:0] fall_reg;
    logic [CW-1:0] high_reg;
    logic [CW-1:0] period_reg;
    logic          range_reg;

    // divider
    logic           busy_reg;
    logic [SW-1:0]  step_reg;
    logic [DDW-1:0] quot_reg;
    logic [DSW-1:0] rem_reg;
    logic [DSW-1:0] dvs_reg;
    logic [DSW:0]   shifted;
    logic [DSW:0]   trial;
    logic           ge;

    logic [OW-1:0]  freq_reg;
    logic [OW-1:0]  freq_sat;
    logic           out_valid_reg;

    assign sts.rise        = signal_level && !prev_level_reg;
    assign sts.fall        = !signal_level && prev_level_reg;
    assign sts.range_ok    = (first_rise_reg < fall_reg) && (fall_reg < tick_reg);
    assign sts.div_busy    = busy_reg;
    assign sts.out_pending = out_valid_reg;

    assign tick_next = cmd.cap_second ? '0 : tick_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            tick_reg       <= '0;
            first_rise_reg <= '0;
            fall_reg       <= '0;
        end
        else if (cmd.take)
        begin
            prev_level_reg <= signal_level;
            tick_reg       <= tick_next;
            if (cmd.cap_first)
                first_rise_reg <= tick_reg;
            if (cmd.cap_fall)
                fall_reg <= tick_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_second)
        begin
            high_reg   <= fall_reg - first_rise_reg;
            period_reg <= tick_reg - first_rise_reg;
            range_reg  <= sts.range_ok;
        end
    end

    // one quotient bit per cycle
    assign shifted = {rem_reg, quot_reg[DDW-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign ge      = !trial[DSW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            busy_reg <= 1'b1;
            step_reg <= SW'(DDW);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - SW'(1);
            if (step_reg == SW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            if (cmd.div_sel_duty)
            begin
                quot_reg <= DDW'(high_reg) * DDW'(pwmfdm_pkg::DUTY_SCALE);
                dvs_reg  <= DSW'(period_reg);
            end
            else
            begin
                // floor(floor(c/p)/1000) == floor(c/(p*1000))
                quot_reg <= DDW'(clock_hz);
                dvs_reg  <= DSW'(period_reg) * DSW'(pwmfdm_pkg::FREQ_SCALE);
            end
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? trial[DSW-1:0] : shifted[DSW-1:0];
            quot_reg <= {quot_reg[DDW-2:0], ge};
        end
    end

    assign freq_sat = (|quot_reg[DDW-1:OW]) ? '1 : quot_reg[OW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.freq_latch)
            freq_reg <= freq_sat;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            in_range     <= range_reg;
            high_ticks   <= range_reg ? OW'(high_reg) : '0;
            period_ticks <= range_reg ? OW'(period_reg) : '0;
            freq_khz     <= range_reg ? freq_reg : '0;
            duty_percent <= range_reg ? quot_reg[UW-1:0] : '0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/core/pwm_frequency_duty_meter_core.sv */
// Throughput: one tick transaction per cycle while a measurement is collecting edges.
// A result is offered once the tick with the closing rising edge has gone through two 27-step passes
// of the shared restoring divider plus sequencing; an out-of-range result skips the divider.
// Ticks are held off during that computation and while an unread result blocks the
// closing edge. rst_n is asynchronous: phase, counter, captures, handshakes and
// clock_hz (back to 8000000) are cleared at once.
`default_nettype none

module pwm_frequency_duty_meter_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // tick input channel
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               signal_level,
    // result channel
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    in_range,
    output logic [pwmfdm_pkg::OUT_W-1:0]            high_ticks,
    output logic [pwmfdm_pkg::OUT_W-1:0]            period_ticks,
    output logic [pwmfdm_pkg::OUT_W-1:0]            freq_khz,
    output logic [pwmfdm_pkg::DUTY_W-1:0]           duty_percent,
    // APB configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [pwmfdm_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [pwmfdm_pkg::DATA_W-1:0]      pwdata,
    output logic [pwmfdm_pkg::DATA_W-1:0]           prdata,
    output logic                                    pready
);

    localparam int AW = pwmfdm_pkg::ADDR_W;
    localparam int KW = pwmfdm_pkg::CLK_W;

    pwmfdm_pkg::ctrl_cmd_t  cmd;
    pwmfdm_pkg::dp_status_t sts;

    logic [KW-1:0] clock_hz_reg;
    logic          reg_hit;
    logic          wr_en;

    // --- configuration -------------------------------------------------
    // No wait states; register index is the word address, low byte bits ignored.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[AW-1:2] == pwmfdm_pkg::IDX_CLOCK_HZ);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clock_hz_reg <= pwmfdm_pkg::CLOCK_HZ_RST;
        else if (wr_en && reg_hit)
            clock_hz_reg <= pwdata[KW-1:0];
    end

    assign prdata = reg_hit ? pwmfdm_pkg::DATA_W'(clock_hz_reg) : '0;

    // --- controller: capture phase and divider sequencing ---------------
    pwmfdm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // --- datapath: counter, captures, divider, result register ----------
    pwmfdm_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .signal_level (signal_level),
        .clock_hz     (clock_hz_reg),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .in_range     (in_range),
        .high_ticks   (high_ticks),
        .period_ticks (period_ticks),
        .freq_khz     (freq_khz),
        .duty_percent (duty_percent)
    );

endmodule

`default_nettype wire

/* rtl/core/pwmfdm_checker.sv */
// Port-level checks for the PWM meter, bound to the top level.
// Depends on pwmfdm_pkg and pwm_frequency_duty_meter_core.
`default_nettype none

module pwmfdm_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic                          in_range,
    input  wire logic [pwmfdm_pkg::OUT_W-1:0]  high_ticks,
    input  wire logic [pwmfdm_pkg::OUT_W-1:0]  period_ticks,
    input  wire logic [pwmfdm_pkg::OUT_W-1:0]  freq_khz,
    input  wire logic [pwmfdm_pkg::DUTY_W-1:0] duty_percent
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(in_range) &&
        $stable(high_ticks) && $stable(period_ticks) && $stable(freq_khz) &&
        $stable(duty_percent))
        else $error("result changed while stalled");

    // out of range carries all-zero fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> high_ticks == '0 && period_ticks == '0 &&
        freq_khz == '0 && duty_percent == '0)
        else $error("out-of-range result has non-zero fields");

    // duty is a floor of a fraction below one
    a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_range |-> duty_percent <= pwmfdm_pkg::DUTY_W'(99))
        else $error("duty above 99 percent");

    // ticks are held off while a result is being computed
    a_stall_before_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without input stall");

endmodule

bind pwm_frequency_duty_meter_core pwmfdm_checker u_pwmfdm_checker (.*);

`default_nettype wire

/* tb/tb_pwm_frequency_duty_meter_core.sv */
// Self-checking testbench for pwm_frequency_duty_meter_core: a PWM level stream goes in,
// and each measurement is checked against an in-bench predictor and a result scoreboard.
// Depends on pwmfdm_pkg and the core RTL only.
module tb_pwm_frequency_duty_meter_core;

    localparam int ADDR_W = pwmfdm_pkg::ADDR_W;
    localparam int DATA_W = pwmfdm_pkg::DATA_W;
    localparam int CLK_W  = pwmfdm_pkg::CLK_W;
    localparam int CNT_W  = pwmfdm_pkg::CNT_W;
    localparam int OUT_W  = pwmfdm_pkg::OUT_W;
    localparam int DUTY_W = pwmfdm_pkg::DUTY_W;

    // Register map: clock_hz is register 0; the next word is unmapped and must be ignored.
    localparam logic [ADDR_W-1:0] CLOCK_HZ_ADDR = {pwmfdm_pkg::IDX_CLOCK_HZ, 2'b00};
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(4);

    localparam logic [CLK_W-1:0] CLOCK_HZ_MIN = CLK_W'(1000);
    localparam logic [CLK_W-1:0] CLOCK_HZ_MAX = CLK_W'(100000000);

    localparam int RANDOM_TICKS  = 1240;
    localparam int RANDOM_BLOCKS = 6;
    // settling margin that drain() allows once every owed reading is in
    localparam int SETTLE_CYCLES = 80;
    // receiver back-pressure: one long hold-off once this many results are in
    localparam int HOLD_AFTER    = 10;
    localparam int LONG_HOLD     = 2000;
    // cycles without any transaction on either channel before giving up
    localparam int STALL_LIMIT   = 20000;

    typedef enum logic [1:0] {
        WAIT_FIRST_RISE,
        WAIT_FALL,
        WAIT_SECOND_RISE
    } capture_phase_t;

    typedef struct packed {
        logic              in_range;
        logic [OUT_W-1:0]  high_ticks;
        logic [OUT_W-1:0]  period_ticks;
        logic [OUT_W-1:0]  freq_khz;
        logic [DUTY_W-1:0] duty_percent;
    } reading_t;

    // Predictor of the capture logic plus the queue of readings still owed by the core.
    class meter_scoreboard;
        logic [CLK_W-1:0] clock_hz;
        logic             last_level;
        capture_phase_t   phase;
        logic [CNT_W-1:0] tick_cnt;
        logic [CNT_W-1:0] rise_at;
        logic [CNT_W-1:0] fall_at;
        reading_t         expected_readings[$];
        int               errors;

        function new();
            clock_hz   = pwmfdm_pkg::CLOCK_HZ_RST;
            last_level = 1'b0;
            phase      = WAIT_FIRST_RISE;
            tick_cnt   = '0;
            rise_at    = '0;
            fall_at    = '0;
            errors     = 0;
        endfunction

        function reading_t measure(logic [CNT_W-1:0] rise2_at);
            reading_t        r;
            longint unsigned hz;
            longint unsigned high_t;
            longint unsigned period_t;
            longint unsigned khz;
            r = '0;
            // captures must strictly increase, else the counter wrapped: out of range
            if (rise_at < fall_at && fall_at < rise2_at)
            begin
                hz       = clock_hz;
                high_t   = fall_at - rise_at;
                period_t = rise2_at - rise_at;
                khz      = (hz / period_t) / pwmfdm_pkg::FREQ_SCALE;
                if (khz > 16'hFFFF)
                    khz = 16'hFFFF;
                r.in_range     = 1'b1;
                r.high_ticks   = OUT_W'(high_t);
                r.period_ticks = OUT_W'(period_t);
                r.freq_khz     = OUT_W'(khz);
                r.duty_percent = DUTY_W'(high_t * pwmfdm_pkg::DUTY_SCALE / period_t);
            end
            return r;
        endfunction

        function void note_tick(logic level);
            logic             rise;
            logic             fall;
            logic [CNT_W-1:0] now;
            rise       = !last_level && level;
            fall       = last_level && !level;
            now        = tick_cnt;
            last_level = level;
            tick_cnt   = now + CNT_W'(1);
            case (phase)
                WAIT_FALL:
                    if (fall)
                    begin
                        fall_at = now;
                        phase   = WAIT_SECOND_RISE;
                    end
                WAIT_SECOND_RISE:
                    if (rise)
                    begin
                        expected_readings.push_back(measure(now));
                        phase    = WAIT_FIRST_RISE;
                        tick_cnt = '0;
                    end
                default:
                    if (rise)
                    begin
                        rise_at = now;
                        phase   = WAIT_FALL;
                    end
            endcase
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(reading_t got);
            reading_t want;
            if (expected_readings.size() == 0)
            begin
                $error("result transaction with no measurement outstanding");
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            compare_field("in_range", want.in_range, got.in_range);
            compare_field("high_ticks", want.high_ticks, got.high_ticks);
            compare_field("period_ticks", want.period_ticks, got.period_ticks);
            compare_field("freq_khz", want.freq_khz, got.freq_khz);
            compare_field("duty_percent", want.duty_percent, got.duty_percent);
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              signal_level;
    logic              out_valid;
    logic              out_ready;
    logic              in_range;
    logic [OUT_W-1:0]  high_ticks;
    logic [OUT_W-1:0]  period_ticks;
    logic [OUT_W-1:0]  freq_khz;
    logic [DUTY_W-1:0] duty_percent;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // idling switches, flipped by the stimulus between phases
    bit tx_gaps_on   = 1'b0;
    bit rx_stalls_on = 1'b0;

    meter_scoreboard sb;

    pwm_frequency_duty_meter_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .signal_level (signal_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .in_range     (in_range),
        .high_ticks   (high_ticks),
        .period_ticks (period_ticks),
        .freq_khz     (freq_khz),
        .duty_percent (duty_percent),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly back-to-back, some short gaps, the odd long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else if (r < 98)
            return $urandom_range(12, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    // Length of one run of constant PWM level; short runs dominate so results come often,
    // long runs give low and high duty and small frequencies.
    function automatic int pick_run();
        int r;
        r = $urandom_range(99, 0);
        if (r < 65)
            return $urandom_range(3, 1);
        else if (r < 92)
            return $urandom_range(16, 4);
        else if (r < 98)
            return $urandom_range(120, 17);
        else
            return $urandom_range(300, 121);
    endfunction

    // One tick transaction. Inputs move on the falling edge; acceptance is judged at the
    // rising edge, where the predictor is told about the tick.
    task automatic send_tick(input logic level);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid     = 1'b0;
            signal_level = 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        signal_level = level;
        do @(posedge clk); while (!in_ready);
        sb.note_tick(level);
    endtask

    task automatic send_run(input logic level, input int n);
        repeat (n) send_tick(level);
    endtask

    // Stop offering ticks, wait for every owed reading, then let the datapath settle.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_clock_hz();
        logic [DATA_W-1:0] rd;
        apb_read(CLOCK_HZ_ADDR, rd);
        if (rd[CLK_W-1:0] !== sb.clock_hz)
        begin
            $error("clock_hz: expected %0d, got %0d", sb.clock_hz, rd[CLK_W-1:0]);
            sb.errors++;
        end
    endtask

    task automatic set_clock_hz(input logic [CLK_W-1:0] value);
        apb_write(CLOCK_HZ_ADDR, DATA_W'(value));
        sb.clock_hz = value;
        check_clock_hz();
    endtask

    // Result side: random stalls, plus one long hold-off that fills the core and stalls
    // the tick channel while the sender keeps offering.
    initial
    begin : result_sink
        int       stall_left;
        int       taken;
        bit       held;
        reading_t got;
        out_ready  = 1'b0;
        stall_left = 0;
        taken      = 0;
        held       = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held && taken >= HOLD_AFTER)
            begin
                held       = 1'b1;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && rx_stalls_on)
                stall_left = pick_gap();
            out_ready = (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = {in_range, high_ticks, period_ticks, freq_khz, duty_percent};
                sb.check_result(got);
                taken++;
            end
        end
    end

    // Watchdog: any transaction on either channel restarts the count.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[pwm_frequency_duty_meter_core] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        logic level;
        int   sent;
        int   blk;
        int   run_len;
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        signal_level = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // clock_hz must come out of reset at its default
        check_clock_hz();

        // Directed. A high first sample is a rising edge: period 2, high 1.
        send_run(1'b1, 1);
        send_run(1'b0, 1);
        send_run(1'b1, 1);
        // odd period, duty rounds down
        send_run(1'b0, 2);
        send_run(1'b1, 2);
        send_run(1'b0, 1);
        send_run(1'b1, 1);

        // fastest clock with the shortest period: top of the kHz range
        drain();
        set_clock_hz(CLOCK_HZ_MAX);
        send_run(1'b0, 1);
        send_run(1'b1, 1);
        send_run(1'b0, 1);
        send_run(1'b1, 1);

        // slowest clock: frequency floors to zero
        drain();
        set_clock_hz(CLOCK_HZ_MIN);
        send_run(1'b0, 1);
        send_run(1'b1, 1);
        send_run(1'b0, 1);
        send_run(1'b1, 1);

        // a write to the unmapped word must leave clock_hz alone
        drain();
        apb_write(UNMAPPED_ADDR, $urandom);
        check_clock_hz();

        // A long measurement, then a low tick and a high tick that open the next one.
        set_clock_hz(pwmfdm_pkg::CLOCK_HZ_RST);
        send_run(1'b0, 100);
        send_run(1'b1, 120);
        send_run(1'b0, 60);
        send_run(1'b1, 1);
        send_run(1'b0, 1);
        send_run(1'b1, 1);

        // Random PWM: alternating runs of random length, one clock_hz setting per block.
        level = 1'b1;
        sent  = 0;
        for (blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            drain();
            case (blk)
                0: set_clock_hz(CLOCK_HZ_MAX);
                1: set_clock_hz(CLOCK_HZ_MIN);
                RANDOM_BLOCKS - 1: set_clock_hz(pwmfdm_pkg::CLOCK_HZ_RST);
                default: set_clock_hz(CLK_W'($urandom_range(CLOCK_HZ_MAX, CLOCK_HZ_MIN)));
            endcase
            // one block with no sender gaps, another with no receiver stalls
            tx_gaps_on   = (blk != 2);
            rx_stalls_on = (blk != 3);
            while (sent < (blk + 1) * RANDOM_TICKS / RANDOM_BLOCKS)
            begin
                level   = !level;
                run_len = pick_run();
                send_run(level, run_len);
                sent += run_len;
            end
        end

        drain();
        if (sb.errors == 0)
            $display("[pwm_frequency_duty_meter_core] OK");
        else
            $display("[pwm_frequency_duty_meter_core] ERROR");
        $finish;
    end

endmodule
